/* rtl/core/aabb_uniform_grid_index_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the uniform grid index unit
// ----------------------------------------------------------------------------
`ifndef AABB_UNIFORM_GRID_INDEX_UNIT_MACROS_SVH
`define AABB_UNIFORM_GRID_INDEX_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AGUI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("agui: implication check failed");
`define AGUI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("agui: next-cycle check failed");
`else
`define AGUI_ASSERT_IMP(label, ante, cons)
`define AGUI_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/core/agui_pkg.sv */
// ----------------------------------------------------------------------------
// agui_pkg
// Shared constants, codes and types of the uniform grid index unit.
// ----------------------------------------------------------------------------
package agui_pkg;

    localparam int MAX_BOXES      = 64;
    localparam int BOX_IDX_W      = $clog2(MAX_BOXES);
    localparam int CNT_W          = $clog2(MAX_BOXES + 1);
    localparam int MAX_CELLS_AXIS = 48;
    localparam int AXIS_W         = 6;
    localparam int CELL_TOTAL     = MAX_CELLS_AXIS * MAX_CELLS_AXIS * MAX_CELLS_AXIS;
    localparam int CELL_ADDR_W    = $clog2(CELL_TOTAL);
    localparam int STRIDE_W       = 2 * AXIS_W;

    localparam int COORD_W   = 24;
    localparam int EXT_W     = COORD_W + 2;
    localparam int EDGE_W    = 12;
    localparam int EDGE_MIN  = 90;
    localparam int EDGE_MAX  = 3072;
    localparam int EDGE_ONE  = 256;
    localparam int SPAN_DIV  = 24;

    localparam int DIV_NUM_W = COORD_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam int NUM_CFG   = 6;
    localparam int CFG_IDX_W = 3;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BOXQ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SEGQ  = 2'd3;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EXT_W-1:0]   ext_t;

    typedef struct packed {
        coord_t b_z;
        coord_t b_y;
        coord_t b_x;
        coord_t a_z;
        coord_t a_y;
        coord_t a_x;
    } box_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [EDGE_W-1:0]    den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [MAX_BOXES-1:0] box_bit(input logic [BOX_IDX_W-1:0] idx);
        return {{(MAX_BOXES-1){1'b0}}, 1'b1} << idx;
    endfunction

endpackage

/* rtl/core/agui_req_if.sv */
// ----------------------------------------------------------------------------
// agui_req_if
// Request channel: one item is a load, build or query command.
// ----------------------------------------------------------------------------
interface agui_req_if;
    logic                              valid;
    logic                              ready;
    logic [agui_pkg::KIND_W-1:0]       kind;
    logic signed [agui_pkg::COORD_W-1:0] corner_a_x;
    logic signed [agui_pkg::COORD_W-1:0] corner_a_y;
    logic signed [agui_pkg::COORD_W-1:0] corner_a_z;
    logic signed [agui_pkg::COORD_W-1:0] corner_b_x;
    logic signed [agui_pkg::COORD_W-1:0] corner_b_y;
    logic signed [agui_pkg::COORD_W-1:0] corner_b_z;

    modport source (
        output valid, kind, corner_a_x, corner_a_y, corner_a_z,
               corner_b_x, corner_b_y, corner_b_z,
        input  ready
    );
    modport sink (
        input  valid, kind, corner_a_x, corner_a_y, corner_a_z,
               corner_b_x, corner_b_y, corner_b_z,
        output ready
    );
endinterface

/* rtl/core/agui_rsp_if.sv */
// ----------------------------------------------------------------------------
// agui_rsp_if
// Result channel: one item per candidate box or per status answer.
// ----------------------------------------------------------------------------
interface agui_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [agui_pkg::BOX_IDX_W-1:0]     candidate_index;
    logic                               found;
    logic                               last_of_run;
    logic [agui_pkg::STATUS_W-1:0]      status;

    modport source (
        output valid, candidate_index, found, last_of_run, status,
        input  ready
    );
    modport sink (
        input  valid, candidate_index, found, last_of_run, status,
        output ready
    );
endinterface

/* rtl/core/agui_ram.sv */
// ----------------------------------------------------------------------------
// agui_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module agui_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/agui_div.sv */
// ----------------------------------------------------------------------------
// agui_div
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module agui_div (
    input  logic               clk,
    input  logic               rst_n,
    input  agui_pkg::div_req_t req,
    output agui_pkg::div_rsp_t rsp
);

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [agui_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [agui_pkg::EDGE_W-1:0]          rem_reg;
    logic [agui_pkg::EDGE_W-1:0]          den_reg;
    logic [agui_pkg::DIV_NUM_W-1:0]       quo_reg;

    logic [agui_pkg::EDGE_W:0]            shifted;
    logic [agui_pkg::EDGE_W+1:0]          diff;

    assign shifted = {rem_reg, quo_reg[agui_pkg::DIV_NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            cnt_reg <= agui_pkg::DIV_CNT_W'(agui_pkg::DIV_NUM_W - 1);
            rem_reg <= '0;
            den_reg <= req.den;
            quo_reg <= req.num;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (!diff[agui_pkg::EDGE_W+1])
            begin
                rem_reg <= diff[agui_pkg::EDGE_W-1:0];
                quo_reg <= {quo_reg[agui_pkg::DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[agui_pkg::EDGE_W-1:0];
                quo_reg <= {quo_reg[agui_pkg::DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* rtl/core/aabb_uniform_grid_index_unit.sv */
// ----------------------------------------------------------------------------
// aabb_uniform_grid_index_unit
// Uniform 3D grid broad phase over up to 64 axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command item (load box, build grid, box or segment query);
//   rsp returns result items, the final one of a command flagged last_of_run.
//   cfg_write_en/cfg_index/cfg_data set the scene bounds that seed a box set.
// Steps (one command at a time, req.ready is high only between commands):
//   load          : box RAM write on accept, then a status item.
//   query         : up to six divisions for the cell range, then per
//                   overlapped cell a cell RAM read then a merge, then a
//                   scan of the bit positions up to the highest hit.
//   build         : four divisions for the edge and cell counts, a pass over
//                   every grid cell to clear the cell RAM, then per box up to
//                   six range divisions and a read-modify-write per marked cell.
//   The serial divider and the single cell RAM port pair set the pace of these steps.
// Reset clears the box count, bounds and grid descriptor; the cell RAM is
// cleared over the used cells at each build, so no pass is run after reset.
// A stalled rsp holds its item in the output register; the unit waits for it
// before loading the next result.
// ----------------------------------------------------------------------------
`include "aabb_uniform_grid_index_unit_macros.svh"

module aabb_uniform_grid_index_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    agui_req_if.sink                        req,
    agui_rsp_if.source                      rsp,
    input  logic                            cfg_write_en,
    input  logic [agui_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [agui_pkg::COORD_W-1:0]    cfg_data
);

    localparam int SW = 5;
    localparam logic [SW-1:0] S_IDLE      = 5'd0;
    localparam logic [SW-1:0] S_RESP      = 5'd1;
    localparam logic [SW-1:0] S_BLD_SPAN  = 5'd2;
    localparam logic [SW-1:0] S_EDGE_GO   = 5'd3;
    localparam logic [SW-1:0] S_EDGE_WAIT = 5'd4;
    localparam logic [SW-1:0] S_CPA_GO    = 5'd5;
    localparam logic [SW-1:0] S_CPA_WAIT  = 5'd6;
    localparam logic [SW-1:0] S_STRIDE    = 5'd7;
    localparam logic [SW-1:0] S_BOX_RD    = 5'd8;
    localparam logic [SW-1:0] S_BOX_LD    = 5'd9;
    localparam logic [SW-1:0] S_RNG_GO    = 5'd10;
    localparam logic [SW-1:0] S_RNG_WAIT  = 5'd11;
    localparam logic [SW-1:0] S_ADDR1     = 5'd12;
    localparam logic [SW-1:0] S_ADDR2     = 5'd13;
    localparam logic [SW-1:0] S_WALK_RD   = 5'd14;
    localparam logic [SW-1:0] S_WALK_OP   = 5'd15;
    localparam logic [SW-1:0] S_FIN       = 5'd16;
    localparam logic [SW-1:0] S_EMIT      = 5'd17;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_MARK  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam int AW  = agui_pkg::AXIS_W;
    localparam int CAW = agui_pkg::CELL_ADDR_W;
    localparam int NW  = agui_pkg::DIV_NUM_W;

    // control and configuration state
    logic [SW-1:0]                 state_reg, state_next;
    logic [agui_pkg::CNT_W-1:0]    box_count_reg, box_count_next;
    logic                          set_built_reg, set_built_next;
    agui_pkg::coord_t              scene_reg [agui_pkg::NUM_CFG];
    agui_pkg::coord_t              bound_reg [6], bound_next [6];
    agui_pkg::coord_t              origin_reg [3], origin_next [3];
    logic [agui_pkg::EDGE_W-1:0]   edge_reg, edge_next;
    logic [AW-1:0]                 cpa_reg [3], cpa_next [3];
    logic                          rsp_valid_reg, rsp_valid_next;

    // working registers
    logic [agui_pkg::STRIDE_W-1:0] stride_reg, stride_next;
    logic [agui_pkg::COORD_W-1:0]  span_reg [3], span_next [3];
    logic [agui_pkg::COORD_W-1:0]  big_reg, big_next;
    agui_pkg::ext_t                lo_reg [3], lo_next [3];
    agui_pkg::ext_t                hi_reg [3], hi_next [3];
    logic [AW-1:0]                 r0_reg [3], r0_next [3];
    logic [AW-1:0]                 r1_reg [3], r1_next [3];
    logic                          empty_reg, empty_next;
    logic [1:0]                    ax_reg, ax_next;
    logic                          side_reg, side_next;
    logic [1:0]                    mode_reg, mode_next;
    logic [agui_pkg::BOX_IDX_W-1:0] box_idx_reg, box_idx_next;
    logic [AW-1:0]                 x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [CAW-1:0]                addr_reg, addr_next;
    logic [CAW-1:0]                base_y_reg, base_y_next, base_z_reg, base_z_next;
    logic [agui_pkg::STRIDE_W-1:0] prod_y_reg, prod_y_next;
    logic [CAW-1:0]                prod_z_reg, prod_z_next;
    logic [agui_pkg::MAX_BOXES-1:0] hits_reg, hits_next;
    logic [agui_pkg::BOX_IDX_W-1:0] emit_idx_reg, emit_idx_next;
    logic [agui_pkg::STATUS_W-1:0] resp_status_reg, resp_status_next;
    logic [agui_pkg::BOX_IDX_W-1:0] rsp_idx_reg, rsp_idx_next;
    logic                          rsp_found_reg, rsp_found_next;
    logic                          rsp_last_reg, rsp_last_next;
    logic [agui_pkg::STATUS_W-1:0] rsp_status_reg, rsp_status_next;

    // memories and divider
    logic                          box_we;
    agui_pkg::box_t                box_wdata, box_rdata;
    logic                          cell_we;
    logic [agui_pkg::MAX_BOXES-1:0] cell_wdata, cell_rdata;
    agui_pkg::div_req_t            div_req;
    agui_pkg::div_rsp_t            div_rsp;

    // combinational helpers
    logic                          accept, out_free, box_full;
    logic [agui_pkg::CNT_W-1:0]    eff_count;
    agui_pkg::coord_t              in_a [3], in_b [3];
    agui_pkg::ext_t                rng_v, rng_n, org_ext;
    logic [AW-1:0]                 cpa_m1 [3];
    logic signed [agui_pkg::COORD_W:0] span_diff [3];
    logic [NW-1:0]                 q;

    agui_ram #(
        .WIDTH ($bits(agui_pkg::box_t)),
        .DEPTH (agui_pkg::MAX_BOXES)
    ) u_box_ram (
        .clk   (clk),
        .we    (box_we),
        .waddr (eff_count[agui_pkg::BOX_IDX_W-1:0]),
        .wdata (box_wdata),
        .raddr (box_idx_reg),
        .rdata (box_rdata)
    );

    agui_ram #(
        .WIDTH (agui_pkg::MAX_BOXES),
        .DEPTH (agui_pkg::CELL_TOTAL)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (addr_reg),
        .wdata (cell_wdata),
        .raddr (addr_reg),
        .rdata (cell_rdata)
    );

    agui_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign eff_count = set_built_reg ? '0 : box_count_reg;
    assign box_full  = (eff_count == agui_pkg::CNT_W'(agui_pkg::MAX_BOXES));
    assign q         = div_rsp.quo;

    assign in_a[0] = req.corner_a_x;
    assign in_a[1] = req.corner_a_y;
    assign in_a[2] = req.corner_a_z;
    assign in_b[0] = req.corner_b_x;
    assign in_b[1] = req.corner_b_y;
    assign in_b[2] = req.corner_b_z;

    assign box_wdata = '{b_z: in_b[2], b_y: in_b[1], b_x: in_b[0],
                         a_z: in_a[2], a_y: in_a[1], a_x: in_a[0]};
    assign box_we    = accept && req.kind == agui_pkg::KIND_LOAD && !box_full;

    assign rng_v   = side_reg ? hi_reg[ax_reg] : lo_reg[ax_reg];
    assign org_ext = {{2{origin_reg[ax_reg][agui_pkg::COORD_W-1]}}, origin_reg[ax_reg]};
    assign rng_n   = rng_v - org_ext;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cpa_m1[i]    = cpa_reg[i] - 1'b1;
            span_diff[i] = {bound_reg[3+i][agui_pkg::COORD_W-1], bound_reg[3+i]}
                         - {bound_reg[i][agui_pkg::COORD_W-1], bound_reg[i]};
        end
    end

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = edge_reg;
        case (state_reg)
            S_EDGE_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = NW'(big_reg);
                div_req.den   = agui_pkg::EDGE_W'(agui_pkg::SPAN_DIV);
            end
            S_CPA_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = NW'(span_reg[ax_reg]) + NW'(edge_reg) - 1'b1;
            end
            S_RNG_GO:
            begin
                div_req.start = !rng_n[agui_pkg::EXT_W-1];
                div_req.num   = rng_n[NW-1:0];
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cell_we    = 1'b0;
        cell_wdata = '0;
        if (state_reg == S_WALK_OP)
        begin
            if (mode_reg == MODE_CLEAR)
            begin
                cell_we = 1'b1;
            end
            else if (mode_reg == MODE_MARK)
            begin
                cell_we    = 1'b1;
                cell_wdata = cell_rdata | agui_pkg::box_bit(box_idx_reg);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        box_count_next   = box_count_reg;
        set_built_next   = set_built_reg;
        bound_next       = bound_reg;
        origin_next      = origin_reg;
        edge_next        = edge_reg;
        cpa_next         = cpa_reg;
        rsp_valid_next   = rsp_valid_reg;
        stride_next      = stride_reg;
        span_next        = span_reg;
        big_next         = big_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        r0_next          = r0_reg;
        r1_next          = r1_reg;
        empty_next       = empty_reg;
        ax_next          = ax_reg;
        side_next        = side_reg;
        mode_next        = mode_reg;
        box_idx_next     = box_idx_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        z_next           = z_reg;
        addr_next        = addr_reg;
        base_y_next      = base_y_reg;
        base_z_next      = base_z_reg;
        prod_y_next      = prod_y_reg;
        prod_z_next      = prod_z_reg;
        hits_next        = hits_reg;
        emit_idx_next    = emit_idx_reg;
        resp_status_next = resp_status_reg;
        rsp_idx_next     = rsp_idx_reg;
        rsp_found_next   = rsp_found_reg;
        rsp_last_next    = rsp_last_reg;
        rsp_status_next  = rsp_status_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ax_next    = '0;
                    side_next  = 1'b0;
                    empty_next = 1'b0;
                    hits_next  = '0;
                    mode_next  = MODE_QUERY;
                    state_next = S_RESP;
                    case (req.kind)
                        agui_pkg::KIND_LOAD:
                        begin
                            set_built_next = 1'b0;
                            if (box_full)
                            begin
                                resp_status_next = agui_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                resp_status_next = agui_pkg::STATUS_OK;
                                box_count_next   = eff_count + 1'b1;
                                for (int i = 0; i < 3; i++)
                                begin
                                    // first box of a set starts from the scene bounds
                                    agui_pkg::coord_t bmin, bmax;
                                    bmin = (eff_count == '0) ? scene_reg[i] : bound_reg[i];
                                    bmax = (eff_count == '0) ? scene_reg[3+i] : bound_reg[3+i];
                                    bound_next[i]   = (in_a[i] < bmin) ? in_a[i] : bmin;
                                    bound_next[3+i] = (in_b[i] > bmax) ? in_b[i] : bmax;
                                end
                            end
                        end
                        agui_pkg::KIND_BUILD:
                        begin
                            set_built_next = 1'b1;
                            if (box_count_reg == '0 || set_built_reg)
                            begin
                                if (box_count_reg == '0)
                                begin
                                    edge_next = agui_pkg::EDGE_W'(agui_pkg::EDGE_ONE);
                                    for (int i = 0; i < 3; i++)
                                    begin
                                        origin_next[i] = '0;
                                        cpa_next[i]    = '0;
                                    end
                                    resp_status_next = agui_pkg::STATUS_EMPTY;
                                end
                                else
                                begin
                                    state_next = S_BLD_SPAN;
                                end
                            end
                            else
                            begin
                                state_next = S_BLD_SPAN;
                            end
                        end
                        default:
                        begin
                            if (cpa_reg[0] == '0)
                            begin
                                resp_status_next = agui_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = S_RNG_GO;
                                for (int i = 0; i < 3; i++)
                                begin
                                    agui_pkg::ext_t ea, eb, pad;
                                    ea  = {{2{in_a[i][agui_pkg::COORD_W-1]}}, in_a[i]};
                                    eb  = {{2{in_b[i][agui_pkg::COORD_W-1]}}, in_b[i]};
                                    pad = agui_pkg::EXT_W'(edge_reg[agui_pkg::EDGE_W-1:1]);
                                    if (req.kind == agui_pkg::KIND_BOXQ)
                                    begin
                                        lo_next[i] = ea;
                                        hi_next[i] = eb;
                                    end
                                    else
                                    begin
                                        lo_next[i] = ((ea < eb) ? ea : eb) - pad;
                                        hi_next[i] = ((ea > eb) ? ea : eb) + pad;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_idx_next    = '0;
                    rsp_found_next  = 1'b0;
                    rsp_last_next   = 1'b1;
                    rsp_status_next = resp_status_reg;
                    state_next      = S_IDLE;
                end
            end

            S_BLD_SPAN:
            begin
                big_next = '0;
                for (int i = 0; i < 3; i++)
                begin
                    logic [agui_pkg::COORD_W-1:0] s;
                    s = (span_diff[i] < (agui_pkg::COORD_W+1)'(agui_pkg::EDGE_MIN))
                        ? agui_pkg::COORD_W'(agui_pkg::EDGE_MIN)
                        : span_diff[i][agui_pkg::COORD_W-1:0];
                    span_next[i]   = s;
                    origin_next[i] = bound_reg[i];
                    if (s > big_next)
                    begin
                        big_next = s;
                    end
                end
                state_next = S_EDGE_GO;
            end

            S_EDGE_GO:
            begin
                state_next = S_EDGE_WAIT;
            end

            S_EDGE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (q < NW'(agui_pkg::EDGE_MIN))
                    begin
                        edge_next = agui_pkg::EDGE_W'(agui_pkg::EDGE_MIN);
                    end
                    else if (q > NW'(agui_pkg::EDGE_MAX))
                    begin
                        edge_next = agui_pkg::EDGE_W'(agui_pkg::EDGE_MAX);
                    end
                    else
                    begin
                        edge_next = q[agui_pkg::EDGE_W-1:0];
                    end
                    ax_next    = '0;
                    state_next = S_CPA_GO;
                end
            end

            S_CPA_GO:
            begin
                state_next = S_CPA_WAIT;
            end

            S_CPA_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (q == '0)
                    begin
                        cpa_next[ax_reg] = AW'(1);
                    end
                    else if (q > NW'(agui_pkg::MAX_CELLS_AXIS))
                    begin
                        cpa_next[ax_reg] = AW'(agui_pkg::MAX_CELLS_AXIS);
                    end
                    else
                    begin
                        cpa_next[ax_reg] = q[AW-1:0];
                    end
                    if (ax_reg == 2'd2)
                    begin
                        state_next = S_STRIDE;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = S_CPA_GO;
                    end
                end
            end

            S_STRIDE:
            begin
                // clear pass walks every cell of the new grid
                stride_next = cpa_reg[0] * cpa_reg[1];
                for (int i = 0; i < 3; i++)
                begin
                    r0_next[i] = '0;
                    r1_next[i] = cpa_m1[i];
                end
                x_next      = '0;
                y_next      = '0;
                z_next      = '0;
                addr_next   = '0;
                base_y_next = '0;
                base_z_next = '0;
                mode_next   = MODE_CLEAR;
                state_next  = S_WALK_OP;
            end

            S_BOX_RD:
            begin
                state_next = S_BOX_LD;
            end

            S_BOX_LD:
            begin
                lo_next[0] = {{2{box_rdata.a_x[agui_pkg::COORD_W-1]}}, box_rdata.a_x};
                lo_next[1] = {{2{box_rdata.a_y[agui_pkg::COORD_W-1]}}, box_rdata.a_y};
                lo_next[2] = {{2{box_rdata.a_z[agui_pkg::COORD_W-1]}}, box_rdata.a_z};
                hi_next[0] = {{2{box_rdata.b_x[agui_pkg::COORD_W-1]}}, box_rdata.b_x};
                hi_next[1] = {{2{box_rdata.b_y[agui_pkg::COORD_W-1]}}, box_rdata.b_y};
                hi_next[2] = {{2{box_rdata.b_z[agui_pkg::COORD_W-1]}}, box_rdata.b_z};
                ax_next    = '0;
                side_next  = 1'b0;
                empty_next = 1'b0;
                mode_next  = MODE_MARK;
                state_next = S_RNG_GO;
            end

            S_RNG_GO:
            begin
                if (rng_n[agui_pkg::EXT_W-1])
                begin
                    // below the origin: start clips to cell 0, an end makes the range empty
                    if (side_reg)
                    begin
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        r0_next[ax_reg] = '0;
                    end
                    side_next = !side_reg;
                    if (side_reg)
                    begin
                        ax_next = ax_reg + 1'b1;
                    end
                    if (side_reg && ax_reg == 2'd2)
                    begin
                        state_next = S_ADDR1;
                    end
                end
                else
                begin
                    state_next = S_RNG_WAIT;
                end
            end

            S_RNG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (!side_reg)
                    begin
                        if (q > NW'(cpa_m1[ax_reg]))
                        begin
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            r0_next[ax_reg] = q[AW-1:0];
                        end
                    end
                    else
                    begin
                        r1_next[ax_reg] = (q > NW'(cpa_m1[ax_reg])) ? cpa_m1[ax_reg] : q[AW-1:0];
                    end
                    side_next = !side_reg;
                    if (side_reg)
                    begin
                        ax_next = ax_reg + 1'b1;
                    end
                    state_next = (side_reg && ax_reg == 2'd2) ? S_ADDR1 : S_RNG_GO;
                end
            end

            S_ADDR1:
            begin
                prod_y_next = r0_reg[1] * cpa_reg[0];
                prod_z_next = CAW'(r0_reg[2] * stride_reg);
                if (empty_reg || r0_reg[0] > r1_reg[0] || r0_reg[1] > r1_reg[1]
                    || r0_reg[2] > r1_reg[2])
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_ADDR2;
                end
            end

            S_ADDR2:
            begin
                addr_next   = CAW'(r0_reg[0]) + CAW'(prod_y_reg) + prod_z_reg;
                base_y_next = CAW'(r0_reg[0]) + CAW'(prod_y_reg) + prod_z_reg;
                base_z_next = CAW'(r0_reg[0]) + CAW'(prod_y_reg) + prod_z_reg;
                x_next      = r0_reg[0];
                y_next      = r0_reg[1];
                z_next      = r0_reg[2];
                state_next  = S_WALK_RD;
            end

            S_WALK_RD:
            begin
                state_next = S_WALK_OP;
            end

            S_WALK_OP:
            begin
                if (mode_reg == MODE_QUERY)
                begin
                    hits_next = hits_reg | cell_rdata;
                end
                state_next = (mode_reg == MODE_CLEAR) ? S_WALK_OP : S_WALK_RD;
                if (x_reg != r1_reg[0])
                begin
                    x_next    = x_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                else if (y_reg != r1_reg[1])
                begin
                    y_next      = y_reg + 1'b1;
                    x_next      = r0_reg[0];
                    base_y_next = base_y_reg + CAW'(cpa_reg[0]);
                    addr_next   = base_y_reg + CAW'(cpa_reg[0]);
                end
                else if (z_reg != r1_reg[2])
                begin
                    z_next      = z_reg + 1'b1;
                    y_next      = r0_reg[1];
                    x_next      = r0_reg[0];
                    base_z_next = base_z_reg + CAW'(stride_reg);
                    base_y_next = base_z_reg + CAW'(stride_reg);
                    addr_next   = base_z_reg + CAW'(stride_reg);
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                case (mode_reg)
                    MODE_CLEAR:
                    begin
                        box_idx_next = '0;
                        state_next   = S_BOX_RD;
                    end
                    MODE_MARK:
                    begin
                        if (agui_pkg::CNT_W'(box_idx_reg) + 1'b1 == box_count_reg)
                        begin
                            resp_status_next = agui_pkg::STATUS_OK;
                            state_next       = S_RESP;
                        end
                        else
                        begin
                            box_idx_next = box_idx_reg + 1'b1;
                            state_next   = S_BOX_RD;
                        end
                    end
                    default:
                    begin
                        emit_idx_next    = '0;
                        resp_status_next = agui_pkg::STATUS_OK;
                        state_next       = (hits_reg == '0) ? S_RESP : S_EMIT;
                    end
                endcase
            end

            S_EMIT:
            begin
                if (!hits_reg[emit_idx_reg])
                begin
                    emit_idx_next = emit_idx_reg + 1'b1;
                end
                else if (out_free)
                begin
                    hits_next       = hits_reg & ~agui_pkg::box_bit(emit_idx_reg);
                    rsp_valid_next  = 1'b1;
                    rsp_idx_next    = emit_idx_reg;
                    rsp_found_next  = 1'b1;
                    rsp_status_next = agui_pkg::STATUS_OK;
                    rsp_last_next   = (hits_next == '0);
                    emit_idx_next   = emit_idx_reg + 1'b1;
                    if (hits_next == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_count_reg <= '0;
            set_built_reg <= 1'b0;
            edge_reg      <= agui_pkg::EDGE_W'(agui_pkg::EDGE_ONE);
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < agui_pkg::NUM_CFG; i++)
            begin
                scene_reg[i] <= '0;
                bound_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= '0;
                cpa_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            box_count_reg <= box_count_next;
            set_built_reg <= set_built_next;
            edge_reg      <= edge_next;
            rsp_valid_reg <= rsp_valid_next;
            bound_reg     <= bound_next;
            origin_reg    <= origin_next;
            cpa_reg       <= cpa_next;
            if (cfg_write_en && cfg_index < agui_pkg::CFG_IDX_W'(agui_pkg::NUM_CFG))
            begin
                scene_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stride_reg      <= stride_next;
        span_reg        <= span_next;
        big_reg         <= big_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        r0_reg          <= r0_next;
        r1_reg          <= r1_next;
        empty_reg       <= empty_next;
        ax_reg          <= ax_next;
        side_reg        <= side_next;
        mode_reg        <= mode_next;
        box_idx_reg     <= box_idx_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        z_reg           <= z_next;
        addr_reg        <= addr_next;
        base_y_reg      <= base_y_next;
        base_z_reg      <= base_z_next;
        prod_y_reg      <= prod_y_next;
        prod_z_reg      <= prod_z_next;
        hits_reg        <= hits_next;
        emit_idx_reg    <= emit_idx_next;
        resp_status_reg <= resp_status_next;
        rsp_idx_reg     <= rsp_idx_next;
        rsp_found_reg   <= rsp_found_next;
        rsp_last_reg    <= rsp_last_next;
        rsp_status_reg  <= rsp_status_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.candidate_index = rsp_idx_reg;
    assign rsp.found           = rsp_found_reg;
    assign rsp.last_of_run     = rsp_last_reg;
    assign rsp.status          = rsp_status_reg;

    `AGUI_ASSERT_IMP(a_cell_wr_in_walk, cell_we, state_reg == S_WALK_OP)
    `AGUI_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy)
    `AGUI_ASSERT_IMP(a_box_wr_room, box_we, eff_count < agui_pkg::CNT_W'(agui_pkg::MAX_BOXES))
    `AGUI_ASSERT_NXT(a_emit_clears_hit, state_reg == S_EMIT && hits_reg[emit_idx_reg] && out_free, !hits_reg[$past(emit_idx_reg)] && rsp.valid)

endmodule
